/* sv/tgarle_pkg.sv */
package tgarle_pkg;

    localparam int REG_ADDR_W = 4;

    localparam logic [1:0] REG_RLE_MODE = 2'd0;
    localparam logic [1:0] REG_BPP      = 2'd1;
    localparam logic [1:0] REG_WIDTH    = 2'd2;
    localparam logic [1:0] REG_HEIGHT   = 2'd3;

    localparam logic [2:0] BPP_RESET    = 3'd4;

    typedef struct packed {
        logic        rle_mode;
        logic [2:0]  pixel_size;
        logic [31:0] total;
        logic        restart;
        logic        restart_rle;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] first_position;
        logic [7:0]  repeat_count;
        logic        image_done;
    } t_result;

endpackage

/* sv/tgarle_cfg.sv */
module tgarle_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tgarle_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output tgarle_pkg::t_cfg                 o_cfg
);

    logic        r_rle;
    logic [2:0]  r_bpp;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_total;
    logic [31:0] n_total;
    logic [15:0] w_mul_a;
    logic [15:0] w_mul_b;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_comb begin
        w_mul_a = r_width;
        w_mul_b = r_height;
        if (w_wr && w_idx == tgarle_pkg::REG_WIDTH) begin
            w_mul_a = pwdata[15:0];
        end
        if (w_wr && w_idx == tgarle_pkg::REG_HEIGHT) begin
            w_mul_b = pwdata[15:0];
        end
        n_total = w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle    <= 1'b0;
            r_bpp    <= tgarle_pkg::BPP_RESET;
            r_width  <= '0;
            r_height <= '0;
            r_total  <= '0;
        end else if (w_wr) begin
            r_total <= n_total;
            case (w_idx)
                tgarle_pkg::REG_RLE_MODE: r_rle    <= pwdata[0];
                tgarle_pkg::REG_BPP:      r_bpp    <= pwdata[2:0];
                tgarle_pkg::REG_WIDTH:    r_width  <= pwdata[15:0];
                tgarle_pkg::REG_HEIGHT:   r_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tgarle_pkg::REG_RLE_MODE: prdata = {31'd0, r_rle};
            tgarle_pkg::REG_BPP:      prdata = {29'd0, r_bpp};
            tgarle_pkg::REG_WIDTH:    prdata = {16'd0, r_width};
            tgarle_pkg::REG_HEIGHT:   prdata = {16'd0, r_height};
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.rle_mode    = r_rle;
        o_cfg.pixel_size  = (r_bpp == 3'd2 || r_bpp == 3'd3) ? r_bpp : 3'd4;
        o_cfg.total       = r_total;
        o_cfg.restart     = w_wr;
        o_cfg.restart_rle = (w_idx == tgarle_pkg::REG_RLE_MODE) ? pwdata[0] : r_rle;
    end

endmodule

/* sv/tgarle_core.sv */
module tgarle_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgarle_pkg::t_cfg    i_cfg,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    output logic                o_push,
    output tgarle_pkg::t_result o_result
);

    logic [7:0]  r_pb [4];
    logic [7:0]  n_pb [4];
    logic [7:0]  w_cur [4];
    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    logic [2:0]  w_idx_inc;
    logic        r_exp;
    logic        n_exp;
    logic        r_run;
    logic        n_run;
    logic [7:0]  r_cnt;
    logic [7:0]  n_cnt;
    logic [7:0]  w_cnt_dec;
    logic [31:0] r_pos;
    logic [31:0] n_pos;
    logic [31:0] w_left;
    logic [7:0]  w_rep;
    logic        w_full;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_cur[k] = (r_idx[1:0] == 2'(k)) ? i_data_byte : r_pb[k];
        end
    end

    assign w_full    = r_pos >= i_cfg.total;
    assign w_idx_inc = r_idx + 3'd1;
    assign w_left    = i_cfg.total - r_pos;
    assign w_cnt_dec = (r_cnt != 8'd0) ? r_cnt - 8'd1 : 8'd0;

    always_comb begin
        n_pb   = r_pb;
        n_idx  = r_idx;
        n_exp  = r_exp;
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        o_push = 1'b0;
        w_rep  = 8'd1;

        if (i_cfg.pixel_size == 3'd2) begin
            o_result.red   = {w_cur[1][6:2], 3'b000};
            o_result.green = {w_cur[1][1:0], w_cur[0][7:5], 3'b000};
            o_result.blue  = {w_cur[0][4:0], 3'b000};
            o_result.alpha = {w_cur[1][7], 7'd0};
        end else begin
            o_result.red   = w_cur[2];
            o_result.green = w_cur[1];
            o_result.blue  = w_cur[0];
            o_result.alpha = (i_cfg.pixel_size == 3'd4) ? w_cur[3] : 8'hFF;
        end

        if (i_cfg.rle_mode) begin
            if (r_run) begin
                w_rep = (w_left < {24'd0, r_cnt}) ? w_left[7:0] : r_cnt;
            end
            if (w_rep == 8'd0) begin
                w_rep = 8'd1;
            end
        end

        if (i_cfg.restart) begin
            n_idx = '0;
            n_exp = i_cfg.restart_rle;
            n_run = 1'b0;
            n_cnt = '0;
            n_pos = '0;
        end else if (i_accept && !w_full) begin
            if (r_exp) begin
                n_run = i_data_byte[7];
                n_cnt = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_exp = 1'b0;
                n_idx = '0;
            end else begin
                n_pb[r_idx[1:0]] = i_data_byte;
                if (w_idx_inc < i_cfg.pixel_size) begin
                    n_idx = w_idx_inc;
                end else begin
                    n_idx  = '0;
                    o_push = 1'b1;
                    n_pos  = r_pos + {24'd0, w_rep};
                    if (i_cfg.rle_mode) begin
                        if (r_run) begin
                            n_cnt = '0;
                            n_exp = 1'b1;
                        end else begin
                            n_cnt = w_cnt_dec;
                            if (w_cnt_dec == 8'd0) begin
                                n_exp = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        o_result.first_position = r_pos;
        o_result.repeat_count   = w_rep;
        o_result.image_done     = n_pos == i_cfg.total;
    end

    always_ff @(posedge i_clk) begin
        r_pb <= n_pb;
        if (!i_rst_n) begin
            r_idx <= '0;
            r_exp <= 1'b0;
            r_run <= 1'b0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            r_idx <= n_idx;
            r_exp <= n_exp;
            r_run <= n_run;
            r_cnt <= n_cnt;
            r_pos <= n_pos;
        end
    end

endmodule

/* sv/tgarle_obuf.sv */
module tgarle_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgarle_pkg::t_result i_result,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_full,
    output tgarle_pkg::t_result o_result
);

    tgarle_pkg::t_result r_slot0;
    tgarle_pkg::t_result r_slot1;
    logic [1:0]          r_count;
    logic [1:0]          n_count;
    logic                w_pop;

    assign o_valid  = r_count != 2'd0;
    assign o_full   = r_count == 2'd2;
    assign o_result = r_slot0;
    assign w_pop    = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_count == 2'd2) begin
                r_slot0 <= r_slot1;
            end else if (i_push) begin
                r_slot0 <= i_result;
            end
            if (i_push && r_count == 2'd2) begin
                r_slot1 <= i_result;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_slot0 <= i_result;
            end else begin
                r_slot1 <= i_result;
            end
        end
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

/* sv/targa_rle_pixel_decoder.sv */
// A result is registered into the output buffer when the byte that completes its pixel is accepted.
// Throughput: one byte per cycle while o_stall is low; results leave through a two-entry output buffer.
// o_stall rises only when that buffer is full, so a stall downstream backs up after two results.
// Reset: i_rst_n is synchronous, active low; registers return to their defaults
// (raw mode, 4 bytes per pixel, zero size) and decoding state clears at once.
module targa_rle_pixel_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tgarle_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    input  logic [7:0]                        i_data_byte,
    output logic                              o_stall,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic [7:0]                        o_alpha,
    output logic [31:0]                       o_first_position,
    output logic [7:0]                        o_repeat_count,
    output logic                              o_image_done
);

    tgarle_pkg::t_cfg    w_cfg;
    tgarle_pkg::t_result w_core_res;
    tgarle_pkg::t_result w_out_res;
    logic                w_push;
    logic                w_full;

    tgarle_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tgarle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_accept    (i_valid && !w_full),
        .i_data_byte (i_data_byte),
        .o_push      (w_push),
        .o_result    (w_core_res)
    );

    tgarle_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_core_res),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_full   (w_full),
        .o_result (w_out_res)
    );

    assign o_stall          = w_full;
    assign o_red            = w_out_res.red;
    assign o_green          = w_out_res.green;
    assign o_blue           = w_out_res.blue;
    assign o_alpha          = w_out_res.alpha;
    assign o_first_position = w_out_res.first_position;
    assign o_repeat_count   = w_out_res.repeat_count;
    assign o_image_done     = w_out_res.image_done;

endmodule

/* sv/tgarle_checker.sv */
module tgarle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_first_position,
    input logic [7:0]  o_repeat_count,
    input logic        o_image_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_repeat_count != 8'd0) && (o_repeat_count <= 8'd128))
        else $error("repeat count out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_position)
            && $stable(o_repeat_count) && $stable(o_image_done))
        else $error("stalled result changed");

endmodule

bind targa_rle_pixel_decoder tgarle_checker u_tgarle_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_first_position (o_first_position),
    .o_repeat_count   (o_repeat_count),
    .o_image_done     (o_image_done)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    class pixel_scoreboard;
        bit          rle;
        bit [2:0]    bpp;
        bit [15:0]   width;
        bit [15:0]   height;
        bit [7:0]    pix [4];
        bit [2:0]    nbytes;
        bit          want_header;
        bit          in_run;
        int unsigned owed;
        bit [31:0]   position;
        tgarle_pkg::t_result pending_pixels [$];
        int          errors;

        function new();
            rle    = 1'b0;
            bpp    = tgarle_pkg::BPP_RESET;
            width  = '0;
            height = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (pix[i]) pix[i] = '0;
            nbytes      = '0;
            want_header = rle;
            in_run      = 1'b0;
            owed        = 0;
            position    = '0;
        endfunction

        function void write_cfg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                tgarle_pkg::REG_RLE_MODE: rle    = value[0];
                tgarle_pkg::REG_BPP:      bpp    = value[2:0];
                tgarle_pkg::REG_WIDTH:    width  = value[15:0];
                tgarle_pkg::REG_HEIGHT:   height = value[15:0];
                default:                  return;
            endcase
            restart();
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void take_byte(logic [7:0] b);
            longint  total;
            longint  left;
            longint  rep;
            int      size;
            tgarle_pkg::t_result px;
            total = longint'(width) * longint'(height);
            size  = (bpp == 3'd2 || bpp == 3'd3) ? int'(bpp) : 4;
            if (longint'(position) >= total)
                return;
            if (want_header) begin
                in_run      = b[7];
                owed        = int'(b[6:0]) + 1;
                want_header = 1'b0;
                nbytes      = '0;
                return;
            end
            pix[nbytes[1:0]] = b;
            nbytes = nbytes + 3'd1;
            if (int'(nbytes) < size)
                return;
            nbytes = '0;
            if (size == 2) begin
                px.red   = {pix[1][6:2], 3'b000};
                px.green = {pix[1][1:0], pix[0][7:5], 3'b000};
                px.blue  = {pix[0][4:0], 3'b000};
                px.alpha = {pix[1][7], 7'b0};
            end else begin
                px.red   = pix[2];
                px.green = pix[1];
                px.blue  = pix[0];
                px.alpha = (size == 4) ? pix[3] : 8'hff;
            end
            left = total - longint'(position);
            rep  = 1;
            if (rle) begin
                if (in_run) begin
                    rep = owed;
                    if (rep > left)
                        rep = left;
                    owed        = 0;
                    want_header = 1'b1;
                end else begin
                    if (owed > 0)
                        owed--;
                    if (owed == 0)
                        want_header = 1'b1;
                end
                if (rep == 0)
                    rep = 1;
            end
            px.first_position = position;
            px.repeat_count   = rep[7:0];
            position          = position + rep[31:0];
            px.image_done     = (longint'(position) == total);
            pending_pixels.push_back(px);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(tgarle_pkg::t_result got);
            tgarle_pkg::t_result want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, got %0h", $time, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if ($isunknown(got)) begin
                $display("%0t: unknown bits, expected %0h, got %0h", $time, want, got);
                errors++;
                return;
            end
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("alpha", want.alpha, got.alpha);
            compare("first_position", want.first_position, got.first_position);
            compare("repeat_count", want.repeat_count, got.repeat_count);
            compare("image_done", want.image_done, got.image_done);
        endfunction

        function void final_check();
            foreach (pending_pixels[i]) begin
                $display("%0t: missing result, expected %0h, got none", $time,
                         pending_pixels[i]);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [tgarle_pkg::REG_ADDR_W-1:0] paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              i_valid;
    logic [7:0]                        i_data_byte;
    logic                              o_stall;
    logic                              o_valid;
    logic                              i_stall;
    logic [7:0]                        o_red;
    logic [7:0]                        o_green;
    logic [7:0]                        o_blue;
    logic [7:0]                        o_alpha;
    logic [31:0]                       o_first_position;
    logic [7:0]                        o_repeat_count;
    logic                              o_image_done;

    pixel_scoreboard sb = new();
    bit              burst;
    int              bytes_sent;
    bit [2:0]        odd_bpp [5] = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7};

    targa_rle_pixel_decoder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_first_position (o_first_position),
        .o_repeat_count   (o_repeat_count),
        .o_image_done     (o_image_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // downstream stall pattern
    initial begin
        int run;
        int hold;
        i_stall = 1'b0;
        forever begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 3);
            repeat (run) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel({o_red, o_green, o_blue, o_alpha,
                            o_first_position, o_repeat_count, o_image_done});
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_cfg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_image(input bit rle, input bit [2:0] bpp,
                             input bit [15:0] w, input bit [15:0] h);
        logic [31:0] hi;
        hi = $urandom;
        write_reg(tgarle_pkg::REG_RLE_MODE, {hi[31:1], rle});
        hi = $urandom;
        write_reg(tgarle_pkg::REG_BPP, {hi[31:3], bpp});
        hi = $urandom;
        write_reg(tgarle_pkg::REG_WIDTH, {hi[31:16], w});
        hi = $urandom;
        write_reg(tgarle_pkg::REG_HEIGHT, {hi[31:16], h});
    endtask

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic put_pixel(input int size);
        repeat (size) put_byte(8'($urandom));
    endtask

    // hold off the sender until every expected pixel is out and the pipe is quiet
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic stream_packets(input int size, input longint total, input int max_bytes);
        int     start;
        int     cnt;
        longint covered;
        bit     run;
        start   = bytes_sent;
        covered = 0;
        while (covered < total && bytes_sent - start < max_bytes) begin
            run = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, 7);
            put_byte({run, cnt[6:0]});
            if (run)
                put_pixel(size);
            else
                repeat (cnt + 1) put_pixel(size);
            covered += cnt + 1;
        end
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
    endtask

    task automatic stream_raw(input int size, input longint total);
        longint n;
        n = (total < 40) ? total : 40;
        repeat (n) put_pixel(size);
        repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
    endtask

    initial begin
        int       start;
        int       size;
        bit       rle;
        bit [2:0] bpp;
        bit [15:0] w;
        bit [15:0] h;
        longint   total;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        burst       = 1'b0;
        bytes_sent  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // empty image after reset: bytes ignored
        put_byte(8'h5a);
        drain();

        set_image(1'b0, 3'd2, 16'd2, 16'd1);
        put_byte(8'h00); put_byte(8'h00);
        put_byte(8'hff); put_byte(8'hff);
        put_byte(8'h55);
        drain();

        set_image(1'b1, 3'd3, 16'd3, 16'd1);
        put_byte(8'h81);
        put_byte(8'hff); put_byte(8'h00); put_byte(8'h80);
        put_byte(8'h00);
        put_byte(8'h12); put_byte(8'h34); put_byte(8'h56);
        put_byte(8'hff);
        drain();

        // run clipped at the image end
        set_image(1'b1, 3'd4, 16'd5, 16'd1);
        put_byte(8'hff);
        put_byte(8'h00); put_byte(8'hff); put_byte(8'h00); put_byte(8'hff);
        drain();

        // out-of-range pixel size decodes as 4 bytes
        set_image(1'b0, 3'd7, 16'd1, 16'd1);
        put_byte(8'haa); put_byte(8'h55); put_byte(8'haa); put_byte(8'h55);
        drain();

        set_image(1'b1, 3'd2, 16'hffff, 16'hffff);
        put_byte(8'hff);
        put_byte(8'hff); put_byte(8'h7f);
        put_byte(8'h01);
        put_pixel(2);
        put_pixel(2);
        drain();

        start = bytes_sent;
        while (bytes_sent - start < 1700) begin
            rle = 1'($urandom_range(0, 1));
            bpp = ($urandom_range(0, 9) == 0) ? odd_bpp[$urandom_range(0, 4)]
                                              : 3'($urandom_range(2, 4));
            size = (bpp == 3'd2 || bpp == 3'd3) ? int'(bpp) : 4;
            case ($urandom_range(0, 19))
                0: begin
                    w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                    h = (w == 0) ? 16'($urandom) : 16'd0;
                end
                1: begin
                    w = 16'hffff;
                    h = $urandom_range(0, 1) ? 16'hffff : 16'($urandom);
                end
                default: begin
                    w = 16'($urandom_range(1, 10));
                    h = 16'($urandom_range(1, 4));
                end
            endcase
            set_image(rle, bpp, w, h);
            total = longint'(w) * longint'(h);
            burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80) begin
                if (rle)
                    stream_packets(size, total, 150);
                else
                    stream_raw(size, total);
            end else begin
                repeat ($urandom_range(5, 60)) put_byte(8'($urandom));
            end
            burst = 1'b0;
            drain();
        end

        drain();
        repeat (10) @(posedge i_clk);
        sb.final_check();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* targa_rle_pixel_decoder.f */
sv/tgarle_pkg.sv
sv/tgarle_cfg.sv
sv/tgarle_core.sv
sv/tgarle_obuf.sv
sv/targa_rle_pixel_decoder.sv
sv/tgarle_checker.sv
tb/tb_top.sv
